// ===== sv/efr_pkg.sv =====
// Shared codes, result type, CRC and EtherType helpers for the Ethernet frame receiver.
package efr_pkg;

	localparam int MAX_FRAME = 2048;
	localparam int CNT_W = 12;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME);

	localparam logic [2:0] OP_J = 3'd0;
	localparam logic [2:0] OP_K = 3'd1;
	localparam logic [2:0] OP_T = 3'd2;
	localparam logic [2:0] OP_R = 3'd3;
	localparam logic [2:0] OP_DATA = 3'd4;

	localparam logic [2:0] EV_SFD = 3'd0;
	localparam logic [2:0] EV_DST = 3'd1;
	localparam logic [2:0] EV_SRC = 3'd2;
	localparam logic [2:0] EV_TYPE = 3'd3;
	localparam logic [2:0] EV_PAYLOAD = 3'd4;
	localparam logic [2:0] EV_END = 3'd5;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_HUNT = 3'd1;
	localparam logic [2:0] PH_DST = 3'd2;
	localparam logic [2:0] PH_SRC = 3'd3;
	localparam logic [2:0] PH_TYPE = 3'd4;
	localparam logic [2:0] PH_DATA = 3'd5;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
	localparam logic [31:0] CRC_RESIDUE = 32'h2144DF1C;
	localparam logic [7:0] SFD_BYTE = 8'hD5;
	localparam logic [7:0] PREAMBLE_MAX = 8'hFF;
	localparam logic [2:0] MAC_BYTES = 3'd6;
	localparam logic [2:0] TYPE_BYTES = 3'd2;
	localparam logic [CNT_W-1:0] FCS_BYTES = CNT_W'(4);

	localparam int TDATA_W = 88;

	typedef struct packed {
		logic valid;
		logic [2:0] event_res;
		logic [47:0] field_value;
		logic [7:0] preamble_bytes;
		logic dst_bcast;
		logic type_known;
		logic fcs_ok;
		logic [CNT_W-1:0] frame_bytes;
		logic [CNT_W-1:0] payload_bytes;
		logic payload_delivered;
	} efr_result_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic type_is_known(input logic [15:0] t);
		return t inside {
			16'h0800, 16'h0806, 16'h0842, 16'h22F0, 16'h22F3, 16'h22EA, 16'h6002,
			16'h6003, 16'h6004, 16'h8035, 16'h809B, 16'h80F3, 16'h8100, 16'h8102,
			16'h8103, 16'h8137, 16'h8204, 16'h86DD, 16'h8808, 16'h8809, 16'h8819,
			16'h8847, 16'h8848, 16'h8863, 16'h8864, 16'h887B, 16'h888E, 16'h8892,
			16'h889A, 16'h88A2, 16'h88A4, 16'h88A8, 16'h88AB, 16'h88B8, 16'h88B9,
			16'h88BA, 16'h88BF, 16'h88CC, 16'h88CD, 16'h88E3, 16'h88E5, 16'h88E7,
			16'h88F7, 16'h88F8, 16'h88FB, 16'h8902, 16'h8906, 16'h8914, 16'h8915,
			16'h891D, 16'h893A, 16'h892F, 16'h9000, 16'h9100, 16'hF1C1};
	endfunction

endpackage

// ===== sv/ethernet_frame_receiver_fcs_check.sv =====
// Top level of the Ethernet II frame receiver with FCS check.
// The block takes one decoded line symbol per beat and can accept a beat in every
// clock cycle while it is not stalled. Each symbol is captured in an input register,
// and the frame stage then updates the frame state and loads the output register on
// the same clock edge; that stage holds the bytewise CRC-32 update and the parallel
// compare against the table of known EtherTypes, which set the longest path. The
// input side keeps accepting while a result waits in the output register, and stalls
// only when both registers are full.
module ethernet_frame_receiver_fcs_check
	import efr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata,   // data_byte
	input logic [2:0] s_tuser,   // operation
	output logic m_tvalid,
	input logic m_tready,
	// field_value, preamble_bytes, dst_bcast, type_known, fcs_ok, frame_bytes,
	// payload_bytes, payload_delivered, four zero bits
	output logic [TDATA_W-1:0] m_tdata,
	output logic [2:0] m_tuser   // event_res
);

	logic valid_s1;
	logic [2:0] op_s1;
	logic [7:0] byte_s1;
	logic advance;
	logic en;
	efr_result_t res;
	logic m_valid_q;
	efr_result_t m_res_q;

	assign advance = !m_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign en = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	efr_frame u_frame (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.op(op_s1),
		.data_byte(byte_s1),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= en && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && res.valid) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser = m_res_q.event_res;
	assign m_tdata = {4'd0, m_res_q.payload_delivered, m_res_q.payload_bytes,
		m_res_q.frame_bytes, m_res_q.fcs_ok, m_res_q.type_known, m_res_q.dst_bcast,
		m_res_q.preamble_bytes, m_res_q.field_value};

endmodule

// ===== sv/efr_frame.sv =====
// Frame state, header collection, CRC and length counting for the frame receiver.
module efr_frame
	import efr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic [2:0] op,
	input logic [7:0] data_byte,
	output efr_result_t res
);

	logic [2:0] phase_q, phase_d;
	logic seen_j_q, seen_j_d;
	logic [2:0] field_count_q, field_count_d;
	logic [47:0] field_shift_q, field_shift_d;
	logic [7:0] preamble_count_q, preamble_count_d;
	logic [31:0] crc_running_q, crc_running_d;
	logic [31:0] crc_committed_q, crc_committed_d;
	logic [CNT_W-1:0] payload_count_q, payload_count_d;

	logic [31:0] crc_next;
	logic [47:0] shift_next;
	logic [2:0] count_next;
	logic [CNT_W-1:0] hdr_len;
	logic [CNT_W:0] total;

	always_comb begin
		crc_next = crc_byte(crc_running_q, data_byte);
		shift_next = {field_shift_q[39:0], data_byte};
		count_next = field_count_q + 3'd1;
		case (phase_q)
			PH_SRC: hdr_len = CNT_W'(6);
			PH_TYPE: hdr_len = CNT_W'(12);
			PH_DATA: hdr_len = CNT_W'(14);
			default: hdr_len = '0;
		endcase
		total = {1'b0, hdr_len} + {1'b0, payload_count_q};
	end

	always_comb begin
		phase_d = phase_q;
		seen_j_d = seen_j_q;
		field_count_d = field_count_q;
		field_shift_d = field_shift_q;
		preamble_count_d = preamble_count_q;
		crc_running_d = crc_running_q;
		crc_committed_d = crc_committed_q;
		payload_count_d = payload_count_q;
		res = '0;
		res.preamble_bytes = preamble_count_q;

		case (op)
			OP_J: begin
				seen_j_d = 1'b1;
			end
			OP_K, OP_T, OP_R: begin
				if (op == OP_T) begin
					res.valid = 1'b1;
					res.event_res = EV_END;
					res.fcs_ok = ((crc_committed_q ^ CRC_INIT) == CRC_RESIDUE);
					res.frame_bytes = (total > {1'b0, MAX_CNT}) ? MAX_CNT : total[CNT_W-1:0];
					res.payload_delivered = (payload_count_q >= FCS_BYTES);
					res.payload_bytes = res.payload_delivered ?
						(payload_count_q - FCS_BYTES) : '0;
				end
				field_count_d = '0;
				field_shift_d = '0;
				preamble_count_d = '0;
				crc_running_d = CRC_INIT;
				crc_committed_d = CRC_INIT;
				payload_count_d = '0;
				if (op == OP_K && seen_j_q) begin
					phase_d = PH_HUNT;
				end else begin
					phase_d = PH_IDLE;
					seen_j_d = 1'b0;
				end
			end
			OP_DATA: begin
				case (phase_q)
					PH_HUNT: begin
						if (preamble_count_q != PREAMBLE_MAX) begin
							preamble_count_d = preamble_count_q + 8'd1;
						end
						if (data_byte == SFD_BYTE) begin
							phase_d = PH_DST;
							field_count_d = '0;
							field_shift_d = '0;
							res.valid = 1'b1;
							res.event_res = EV_SFD;
							res.preamble_bytes = preamble_count_d;
						end
					end
					PH_DST, PH_SRC, PH_TYPE: begin
						crc_running_d = crc_next;
						field_shift_d = shift_next;
						field_count_d = count_next;
						if ((phase_q == PH_TYPE && count_next == TYPE_BYTES) ||
							(phase_q != PH_TYPE && count_next == MAC_BYTES)) begin
							crc_committed_d = crc_next;
							field_count_d = '0;
							field_shift_d = '0;
							res.valid = 1'b1;
							case (phase_q)
								PH_DST: begin
									phase_d = PH_SRC;
									res.event_res = EV_DST;
									res.field_value = shift_next;
									res.dst_bcast = &shift_next;
								end
								PH_SRC: begin
									phase_d = PH_TYPE;
									res.event_res = EV_SRC;
									res.field_value = shift_next;
								end
								default: begin
									phase_d = PH_DATA;
									res.event_res = EV_TYPE;
									res.field_value = {32'd0, shift_next[15:0]};
									res.type_known = type_is_known(shift_next[15:0]);
								end
							endcase
						end
					end
					PH_DATA: begin
						crc_running_d = crc_next;
						crc_committed_d = crc_next;
						if (payload_count_q < MAX_CNT) begin
							payload_count_d = payload_count_q + CNT_W'(1);
						end
						res.valid = 1'b1;
						res.event_res = EV_PAYLOAD;
						res.field_value = {40'd0, data_byte};
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			seen_j_q <= 1'b0;
			field_count_q <= '0;
			field_shift_q <= '0;
			preamble_count_q <= '0;
			crc_running_q <= CRC_INIT;
			crc_committed_q <= CRC_INIT;
			payload_count_q <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			seen_j_q <= seen_j_d;
			field_count_q <= field_count_d;
			field_shift_q <= field_shift_d;
			preamble_count_q <= preamble_count_d;
			crc_running_q <= crc_running_d;
			crc_committed_q <= crc_committed_d;
			payload_count_q <= payload_count_d;
		end
	end

endmodule

// ===== sv/efr_checker.sv =====
// Port-level checks for the Ethernet frame receiver and their binding to the top level.
module efr_checker
	import efr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic [2:0] m_tuser
);

	// A result that is not taken stays on the port unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Stalled result beat changed or dropped.");

	// Only a frame end carries the check and length fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != EV_END |-> m_tdata[83:58] == '0)
		else $error("Frame end fields set on another event.");

	// The broadcast flag belongs to the destination MAC beat alone.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != EV_DST |-> !m_tdata[56])
		else $error("Broadcast flag set outside the destination MAC beat.");

	// A frame end never reports a length beyond the limit, and no payload
	// length without a delivered payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == EV_END |->
		m_tdata[70:59] <= MAX_CNT && (m_tdata[83] || m_tdata[82:71] == '0))
		else $error("Frame end lengths are inconsistent.");

	// With the output register empty, the input side is always open.
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("Input stalled while no result was pending.");

endmodule

bind ethernet_frame_receiver_fcs_check efr_checker u_efr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser)
);

// ===== sim/ethernet_frame_receiver_fcs_check_tb.sv =====
// Self-checking testbench for the Ethernet II frame receiver with FCS check.
module ethernet_frame_receiver_fcs_check_tb;
	import efr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;
	localparam int LIMIT = 400000;
	localparam int RANDOM_ITEMS = 700;

	typedef struct packed {
		logic [2:0] ev;
		logic [47:0] val;
		logic [7:0] pre;
		logic bc;
		logic tk;
		logic ok;
		logic [CNT_W-1:0] fb;
		logic [CNT_W-1:0] pb;
		logic pd;
	} frame_ev_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] byt;
		logic typed;
		logic fires;
		frame_ev_t want;
	} symbol_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] byt;
		logic typed;
		logic fires;
		logic [2:0] ev;
		logic [47:0] val;
		logic [7:0] pre;
		logic bc;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic [2:0] m_tuser;

	ethernet_frame_receiver_fcs_check dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [15:0] ethertypes [55] = '{
		16'h0800, 16'h0806, 16'h0842, 16'h22F0, 16'h22F3, 16'h22EA, 16'h6002, 16'h6003,
		16'h6004, 16'h8035, 16'h809B, 16'h80F3, 16'h8100, 16'h8102, 16'h8103, 16'h8137,
		16'h8204, 16'h86DD, 16'h8808, 16'h8809, 16'h8819, 16'h8847, 16'h8848, 16'h8863,
		16'h8864, 16'h887B, 16'h888E, 16'h8892, 16'h889A, 16'h88A2, 16'h88A4, 16'h88A8,
		16'h88AB, 16'h88B8, 16'h88B9, 16'h88BA, 16'h88BF, 16'h88CC, 16'h88CD, 16'h88E3,
		16'h88E5, 16'h88E7, 16'h88F7, 16'h88F8, 16'h88FB, 16'h8902, 16'h8906, 16'h8914,
		16'h8915, 16'h891D, 16'h893A, 16'h892F, 16'h9000, 16'h9100, 16'hF1C1
	};

	plan_row_t plan [24] = '{
		'{OP_T, 8'h00, 1'b1, 1'b1, EV_END, 48'h0, 8'd0, 1'b0},
		'{OP_DATA, 8'hFF, 1'b1, 1'b0, EV_SFD, 48'h0, 8'd0, 1'b0},
		'{OP_UNUSED_LO, 8'h00, 1'b1, 1'b0, EV_SFD, 48'h0, 8'd0, 1'b0},
		'{OP_UNUSED_HI, 8'hFF, 1'b1, 1'b0, EV_SFD, 48'h0, 8'd0, 1'b0},
		'{OP_K, 8'h00, 1'b1, 1'b0, EV_SFD, 48'h0, 8'd0, 1'b0},
		'{OP_J, 8'h00, 1'b0, 1'b0, EV_SFD, 48'h0, 8'd0, 1'b0},
		'{OP_K, 8'h00, 1'b0, 1'b0, EV_SFD, 48'h0, 8'd0, 1'b0},
		'{OP_DATA, 8'h55, 1'b1, 1'b0, EV_SFD, 48'h0, 8'd0, 1'b0},
		'{OP_DATA, SFD_BYTE, 1'b1, 1'b1, EV_SFD, 48'h0, 8'd2, 1'b0},
		'{OP_DATA, 8'hFF, 1'b1, 1'b0, EV_SFD, 48'h0, 8'd0, 1'b0},
		'{OP_DATA, 8'hFF, 1'b1, 1'b0, EV_SFD, 48'h0, 8'd0, 1'b0},
		'{OP_DATA, 8'hFF, 1'b1, 1'b0, EV_SFD, 48'h0, 8'd0, 1'b0},
		'{OP_DATA, 8'hFF, 1'b1, 1'b0, EV_SFD, 48'h0, 8'd0, 1'b0},
		'{OP_DATA, 8'hFF, 1'b1, 1'b0, EV_SFD, 48'h0, 8'd0, 1'b0},
		'{OP_DATA, 8'hFF, 1'b1, 1'b1, EV_DST, 48'hFFFF_FFFF_FFFF, 8'd2, 1'b1},
		'{OP_K, 8'h00, 1'b1, 1'b0, EV_SFD, 48'h0, 8'd0, 1'b0},
		'{OP_DATA, SFD_BYTE, 1'b1, 1'b1, EV_SFD, 48'h0, 8'd1, 1'b0},
		'{OP_R, 8'h00, 1'b1, 1'b0, EV_SFD, 48'h0, 8'd0, 1'b0},
		'{OP_J, 8'h00, 1'b0, 1'b0, EV_SFD, 48'h0, 8'd0, 1'b0},
		'{OP_K, 8'h00, 1'b0, 1'b0, EV_SFD, 48'h0, 8'd0, 1'b0},
		'{OP_DATA, SFD_BYTE, 1'b1, 1'b1, EV_SFD, 48'h0, 8'd1, 1'b0},
		'{OP_DATA, 8'h00, 1'b1, 1'b0, EV_SFD, 48'h0, 8'd0, 1'b0},
		'{OP_T, 8'h00, 1'b1, 1'b1, EV_END, 48'h0, 8'd1, 1'b0},
		'{OP_K, 8'h00, 1'b1, 1'b0, EV_SFD, 48'h0, 8'd0, 1'b0}
	};

	symbol_t symbols [$];
	frame_ev_t frame_events [$];
	symbol_t cur;
	frame_ev_t predicted;
	frame_ev_t observed;
	frame_ev_t wanted;
	logic fired;
	int fed = 0;
	int cyc = 0;
	int mismatches = 0;
	int hold_left = 0;
	logic steady;

	logic [2:0] ph;
	logic j_seen;
	int fcnt;
	logic [47:0] fshift;
	logic [7:0] pcnt;
	logic [31:0] crc_run;
	logic [31:0] crc_com;
	logic [CNT_W-1:0] pay;

	assign steady = cyc >= 2500 && cyc < 3300;

	function automatic logic [31:0] fcs_update(input logic [31:0] c, input logic [7:0] d);
		logic [31:0] r;
		r = c;
		for (int i = 0; i < 8; i++) begin
			r = {1'b0, r[31:1]} ^ ((r[0] ^ d[i]) ? CRC_POLY : 32'h0);
		end
		return r;
	endfunction

	function automatic logic ethertype_listed(input logic [15:0] t);
		logic hit;
		hit = 1'b0;
		foreach (ethertypes[i]) begin
			if (ethertypes[i] == t) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	function automatic string event_text(input frame_ev_t e);
		return $sformatf("ev=%0d val=%h pre=%0d bc=%b tk=%b ok=%b fb=%0d pb=%0d pd=%b",
			e.ev, e.val, e.pre, e.bc, e.tk, e.ok, e.fb, e.pb, e.pd);
	endfunction

	task automatic clear_frame();
		fcnt = 0;
		fshift = '0;
		pcnt = '0;
		crc_run = CRC_INIT;
		crc_com = CRC_INIT;
		pay = '0;
	endtask

	task automatic reset_all();
		ph = PH_IDLE;
		j_seen = 1'b0;
		clear_frame();
	endtask

	task automatic frame_step(input logic [2:0] op, input logic [7:0] b,
			output logic hit, output frame_ev_t r);
		int hdr;
		int total;
		int need;
		r = '0;
		hit = 1'b0;
		case (op)
			OP_J: j_seen = 1'b1;
			OP_K: begin
				if (j_seen) begin
					clear_frame();
					ph = PH_HUNT;
				end else begin
					reset_all();
				end
			end
			OP_T: begin
				case (ph)
					PH_SRC: hdr = 6;
					PH_TYPE: hdr = 12;
					PH_DATA: hdr = 14;
					default: hdr = 0;
				endcase
				total = hdr + int'(pay);
				if (total > MAX_FRAME) begin
					total = MAX_FRAME;
				end
				r.ev = EV_END;
				r.pre = pcnt;
				r.ok = (crc_com ^ CRC_INIT) == CRC_RESIDUE;
				r.fb = CNT_W'(total);
				r.pb = (pay >= FCS_BYTES) ? pay - FCS_BYTES : '0;
				r.pd = pay >= FCS_BYTES;
				hit = 1'b1;
				reset_all();
			end
			OP_R: reset_all();
			OP_DATA: begin
				case (ph)
					PH_HUNT: begin
						if (pcnt != PREAMBLE_MAX) begin
							pcnt = pcnt + 8'd1;
						end
						if (b == SFD_BYTE) begin
							ph = PH_DST;
							fcnt = 0;
							fshift = '0;
							r.ev = EV_SFD;
							r.pre = pcnt;
							hit = 1'b1;
						end
					end
					PH_DST, PH_SRC, PH_TYPE: begin
						crc_run = fcs_update(crc_run, b);
						fshift = {fshift[39:0], b};
						fcnt++;
						need = (ph == PH_TYPE) ? int'(TYPE_BYTES) : int'(MAC_BYTES);
						if (fcnt == need) begin
							crc_com = crc_run;
							fcnt = 0;
							hit = 1'b1;
							r.pre = pcnt;
							case (ph)
								PH_DST: begin
									r.ev = EV_DST;
									r.val = fshift;
									r.bc = &fshift;
									ph = PH_SRC;
								end
								PH_SRC: begin
									r.ev = EV_SRC;
									r.val = fshift;
									ph = PH_TYPE;
								end
								default: begin
									r.ev = EV_TYPE;
									r.val = {32'h0, fshift[15:0]};
									r.tk = ethertype_listed(fshift[15:0]);
									ph = PH_DATA;
								end
							endcase
							fshift = '0;
						end
					end
					PH_DATA: begin
						crc_run = fcs_update(crc_run, b);
						crc_com = crc_run;
						if (pay < MAX_CNT) begin
							pay = pay + 1'b1;
						end
						r.ev = EV_PAYLOAD;
						r.val = {40'h0, b};
						r.pre = pcnt;
						hit = 1'b1;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	endtask

	task automatic put(input logic [2:0] op, input logic [7:0] b);
		symbol_t s;
		s = '0;
		s.op = op;
		s.byt = b;
		symbols.push_back(s);
		if (op <= OP_DATA) begin
			fed++;
		end
	endtask

	// Well-formed frames with random content, with some truncated, interrupted,
	// carrying a bad FCS, or left without an end symbol.
	task automatic queue_frame(input bit long_pre, input bit long_pay);
		logic [7:0] body [$];
		logic [47:0] mac;
		logic [15:0] etype;
		logic [31:0] crc;
		int npre;
		int npay;
		int mode;
		int cut;
		int ins;
		int k;
		mode = (long_pre || long_pay) ? 9 : $urandom_range(0, 9);
		case ($urandom_range(0, 9))
			0: put(OP_K, 8'h00);
			1: ;
			2: begin
				put(OP_J, 8'h00);
				put(OP_J, 8'h00);
				put(OP_K, 8'h00);
			end
			default: begin
				put(OP_J, 8'h00);
				put(OP_K, 8'h00);
			end
		endcase
		npre = long_pre ? 300 : $urandom_range(0, 7);
		repeat (npre) begin
			put(OP_DATA, ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h55);
		end
		put(OP_DATA, SFD_BYTE);
		mac = 48'({$urandom, $urandom});
		if ($urandom_range(0, 4) == 0) begin
			mac = '1;
		end
		for (k = 5; k >= 0; k--) begin
			body.push_back(mac[8*k +: 8]);
		end
		mac = 48'({$urandom, $urandom});
		for (k = 5; k >= 0; k--) begin
			body.push_back(mac[8*k +: 8]);
		end
		case ($urandom_range(0, 3))
			0, 1: etype = ethertypes[$urandom_range(0, 54)];
			2: etype = 16'($urandom);
			default: etype = ethertypes[$urandom_range(0, 54)] ^ (16'd1 << $urandom_range(0, 15));
		endcase
		body.push_back(etype[15:8]);
		body.push_back(etype[7:0]);
		if (long_pay) begin
			npay = 2100;
		end else if ($urandom_range(0, 3) == 0) begin
			npay = $urandom_range(0, 5);
		end else begin
			npay = $urandom_range(6, 46);
		end
		repeat (npay) begin
			body.push_back(8'($urandom));
		end
		crc = CRC_INIT;
		foreach (body[i]) begin
			crc = fcs_update(crc, body[i]);
		end
		crc = ~crc;
		for (k = 0; k < 4; k++) begin
			body.push_back(crc[8*k +: 8]);
		end
		if (!long_pay && $urandom_range(0, 4) == 0) begin
			k = $urandom_range(0, body.size() - 1);
			body[k] = body[k] ^ (8'd1 << $urandom_range(0, 7));
		end
		cut = (mode == 0) ? $urandom_range(0, body.size()) : body.size();
		ins = $urandom_range(0, body.size() - 1);
		for (k = 0; k < cut; k++) begin
			if (mode == 1 && k == ins) begin
				case ($urandom_range(0, 4))
					0: put(OP_J, 8'h00);
					1: put(OP_K, 8'h00);
					2: put(OP_R, 8'h00);
					default: put(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), 8'($urandom));
				endcase
			end
			put(OP_DATA, body[k]);
		end
		if (mode != 2) begin
			put(OP_T, 8'h00);
		end
	endtask

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				frame_step(cur.op, cur.byt, fired, predicted);
				if (cur.typed) begin
					if (cur.fires) begin
						frame_events.push_back(cur.want);
					end
				end else if (fired) begin
					frame_events.push_back(predicted);
				end
			end
			if (!s_tvalid || s_tready) begin
				if (symbols.size() != 0 && (steady || $urandom_range(0, 99) >= 30)) begin
					cur = symbols.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= cur.byt;
					s_tuser <= cur.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			observed = {m_tuser, m_tdata[47:0], m_tdata[55:48], m_tdata[56], m_tdata[57],
				m_tdata[58], m_tdata[70:59], m_tdata[82:71], m_tdata[83]};
			if (frame_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected beat at cycle %0d: %s", cyc, event_text(observed));
				end
			end else begin
				wanted = frame_events.pop_front();
				if (observed !== wanted) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at cycle %0d", cyc);
						$display("  want %s", event_text(wanted));
						$display("  got  %s", event_text(observed));
					end
				end
			end
		end
		if (cyc == 900) begin
			hold_left = 150;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || $urandom_range(0, 99) >= 30;
		end
	end

	initial begin
		symbol_t s;
		int fed_mark;
		reset_all();
		foreach (plan[i]) begin
			s = '0;
			s.op = plan[i].op;
			s.byt = plan[i].byt;
			s.typed = plan[i].typed;
			s.fires = plan[i].fires;
			s.want.ev = plan[i].ev;
			s.want.val = plan[i].val;
			s.want.pre = plan[i].pre;
			s.want.bc = plan[i].bc;
			symbols.push_back(s);
		end
		fed = 0;
		for (int f = 0; fed < RANDOM_ITEMS; f++) begin
			if (f == 4 || f == 11) begin
				fed_mark = fed;
				queue_frame(f == 4, f == 11);
				fed = fed_mark;
			end else begin
				queue_frame(1'b0, 1'b0);
			end
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (symbols.size() != 0 || s_tvalid) @(posedge clk);
		while (frame_events.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && frame_events.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
